// ===== rtl/core/h2i_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// h2i_pkg
// Shared types and constants for the binary16 to 64-bit integer converter.
// ----------------------------------------------------------------------------
package h2i_pkg;
   localparam int unsigned EXP_W  = 5;
   localparam int unsigned MANT_W = 10;
   localparam int unsigned INT_W  = 64;
   localparam int unsigned MAG_W  = 17;
   localparam logic [EXP_W-1:0] EXP_MAX  = 5'h1f;
   localparam logic [EXP_W-1:0] EXP_BIAS = 5'd25;
   localparam logic OP_UNSIGNED = 1'b0;
   localparam logic OP_SIGNED   = 1'b1;

   typedef struct packed {
      logic             is_special;
      logic [INT_W-1:0] special_val;
      logic             negate;
      logic             zero;
   } ctl_type;
endpackage : h2i_pkg
`default_nettype wire

// ===== rtl/core/h2i_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// h2i_decode
// Stage 1: split fields, classify, and compute the truncated magnitude.
// ----------------------------------------------------------------------------
module h2i_decode
   import h2i_pkg::*;
(
   input  wire logic             opcode,
   input  wire logic [15:0]      half_bits,
   output      ctl_type          ctl,
   output      logic [MAG_W-1:0] mag
);
   logic             neg;
   logic [EXP_W-1:0] e;
   logic [MANT_W-1:0] m;
   logic [MAG_W-1:0] sig;
   logic [EXP_W-1:0] sh;

   always_comb begin
      neg = half_bits[15];
      e   = half_bits[14:10];
      m   = half_bits[9:0];
      sig = {{(MAG_W-MANT_W-1){1'b0}}, 1'b1, m};
      ctl.is_special  = (e == EXP_MAX);
      ctl.special_val = '0;
      if (m == '0) begin
         if (opcode == OP_SIGNED)
            ctl.special_val = neg ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
         else
            ctl.special_val = neg ? '0 : '1;
      end
      ctl.negate = neg && (opcode == OP_SIGNED);
      ctl.zero   = neg && (opcode == OP_UNSIGNED);
      mag = '0;
      sh  = '0;
      if (e == '0) begin
         mag = '0;
      end else if (e >= EXP_BIAS) begin
         sh  = e - EXP_BIAS;
         mag = sig << sh[2:0];
      end else begin
         sh  = EXP_BIAS - e;
         mag = sig >> sh;
      end
   end
endmodule : h2i_decode
`default_nettype wire

// ===== rtl/core/h2i_result.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// h2i_result
// Stage 2: apply sign, unsigned negative-to-zero clamp or special value to form the 64-bit result.
// ----------------------------------------------------------------------------
module h2i_result
   import h2i_pkg::*;
(
   input  wire ctl_type          ctl,
   input  wire logic [MAG_W-1:0] mag,
   output      logic [INT_W-1:0] result
);
   logic [INT_W-1:0] wide;

   always_comb begin
      wide = {{(INT_W-MAG_W){1'b0}}, mag};
      if (ctl.is_special)
         result = ctl.special_val;
      else if (ctl.zero)
         result = '0;
      else if (ctl.negate)
         result = (~wide) + {{(INT_W-1){1'b0}}, 1'b1};
      else
         result = wide;
   end
endmodule : h2i_result
`default_nettype wire

// ===== rtl/core/half_to_int64_convert_unit.sv =====
`default_nettype none
// A req beat reaches rsp_valid through each register stage in turn and leaves on rsp_ready.
// Throughput: one beat per cycle; each stage holds under a stall.
// Set by the three-stage register chain: input, decoded magnitude, final result.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
// half_to_int64_convert_unit
// Pipelined binary16 to uint64/int64 conversion, truncating toward zero.
// ----------------------------------------------------------------------------
module half_to_int64_convert_unit
   import h2i_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire logic             req_opcode,
   input  wire logic [15:0]      req_half_bits,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      logic [INT_W-1:0] rsp_int_result
);
   logic             v1_ff, v2_ff, v3_ff;
   logic             op_ff;
   logic [15:0]      half_ff;
   ctl_type          ctl_in, ctl_ff;
   logic [MAG_W-1:0] mag_in, mag_ff;
   logic [INT_W-1:0] res_in, res_ff;
   logic             adv1, adv2, adv3;

   assign adv3 = !v3_ff || rsp_ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_ready = adv1;

   h2i_decode u_dec (.opcode(op_ff), .half_bits(half_ff), .ctl(ctl_in), .mag(mag_in));
   h2i_result u_res (.ctl(ctl_ff), .mag(mag_ff), .result(res_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_valid) begin
         op_ff   <= req_opcode;
         half_ff <= req_half_bits;
      end
      if (adv2 && v1_ff) begin
         ctl_ff <= ctl_in;
         mag_ff <= mag_in;
      end
      if (adv3 && v2_ff) res_ff <= res_in;
   end

   assign rsp_valid      = v3_ff;
   assign rsp_int_result = res_ff;

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_int_result))
      else $error("result changed under stall");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      v1_ff && v2_ff && v3_ff && !rsp_ready |-> !req_ready)
      else $error("accepted while pipeline full");
   a_move: assert property (@(posedge clock) disable iff (reset)
      v2_ff && adv3 |=> v3_ff)
      else $error("stage 2 beat lost");
`endif
endmodule : half_to_int64_convert_unit
`default_nettype wire
